// File: sv/bdsd_pkg.sv
package bdsd_pkg;

  // action codes carried in the input tuser
  localparam logic [1:0] ActDisk   = 2'd0;
  localparam logic [1:0] ActNotice = 2'd1;
  localparam logic [1:0] ActEquip  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgMounted = 2'd0;
  localparam logic [1:0] CfgDiskC   = 2'd1;
  localparam logic [1:0] CfgDiskD   = 2'd2;

  // service function codes
  localparam logic [7:0] FnReset     = 8'h00;
  localparam logic [7:0] FnStatus    = 8'h01;
  localparam logic [7:0] FnRead      = 8'h02;
  localparam logic [7:0] FnWrite     = 8'h03;
  localparam logic [7:0] FnVerify    = 8'h04;
  localparam logic [7:0] FnFormat    = 8'h05;
  localparam logic [7:0] FnParams    = 8'h08;
  localparam logic [7:0] FnSeek      = 8'h0C;
  localparam logic [7:0] FnReady     = 8'h10;
  localparam logic [7:0] FnRecal     = 8'h11;
  localparam logic [7:0] FnDiskType  = 8'h15;
  localparam logic [7:0] FnChange    = 8'h16;
  localparam logic [7:0] FnSetType   = 8'h17;
  localparam logic [7:0] FnSetMedia  = 8'h18;

  // status codes returned in AH
  localparam logic [7:0] StOk        = 8'h00;
  localparam logic [7:0] StBadFunc   = 8'h01;
  localparam logic [7:0] StFloppy    = 8'h02;
  localparam logic [7:0] StWriteErr  = 8'h03;
  localparam logic [7:0] StHardDisk  = 8'h03;
  localparam logic [7:0] StReadErr   = 8'h04;
  localparam logic [7:0] StChanged   = 8'h06;
  localparam logic [7:0] StTimeout   = 8'h80;

  // drive codes
  localparam logic [7:0] DrvA = 8'h00;
  localparam logic [7:0] DrvB = 8'h01;
  localparam logic [7:0] DrvC = 8'h80;
  localparam logic [7:0] DrvD = 8'h81;

  // transfer kinds carried in the output tuser
  localparam logic [1:0] XferNone  = 2'd0;
  localparam logic [1:0] XferRead  = 2'd1;
  localparam logic [1:0] XferWrite = 2'd2;

  // geometry and fixed answers
  localparam logic [5:0] FloppySpt   = 6'd18;
  localparam logic [5:0] HddSpt      = 6'd63;
  localparam logic [7:0] EquipBase   = 8'h21;
  localparam logic [7:0] FloppyMaxCyl = 8'd79;
  localparam logic [7:0] HddMaxByte  = 8'hFF;
  localparam logic [7:0] FloppyBl    = 8'h04;

  localparam int unsigned NumDrives  = 4;
  localparam int unsigned SizeW      = 23;
  localparam int unsigned LbaW       = 17;
  localparam int unsigned PhysW      = 21;
  localparam int unsigned BytesW     = 17;
  localparam int unsigned InDataW    = 96;
  localparam int unsigned OutDataW   = 112;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  func;
    logic [7:0]  count;
    logic [7:0]  cyl_low;
    logic [7:0]  sec_cyl_high;
    logic [7:0]  head;
    logic [7:0]  drive;
    logic [7:0]  bl_in;
    logic [15:0] buf_offset;
    logic [15:0] buf_segment;
    logic        transfer_ok;
  } req_t;

  typedef struct packed {
    logic [7:0]        ret_ah;
    logic [7:0]        ret_al;
    logic [7:0]        ret_ch;
    logic [7:0]        ret_cl;
    logic [7:0]        ret_dh;
    logic [7:0]        ret_dl;
    logic [7:0]        ret_bl;
    logic              carry;
    logic [1:0]        transfer_kind;
    logic [LbaW-1:0]   lba;
    logic [PhysW-1:0]  phys_addr;
    logic [BytesW-1:0] byte_count;
  } rsp_t;

  typedef struct packed {
    logic [NumDrives-1:0] mounted_mask;
    logic [SizeW-1:0]     disk_c_sectors;
    logic [SizeW-1:0]     disk_d_sectors;
  } cfg_t;

endpackage

// File: sv/bdsd_exec.sv
module bdsd_exec (
  input  bdsd_pkg::req_t   req_i,
  input  bdsd_pkg::cfg_t   cfg_i,
  input  logic [3:0]       changed_i,
  output logic [3:0]       changed_o,
  output bdsd_pkg::rsp_t   rsp_o
);

  logic       slot_vld;
  logic [1:0] slot;
  logic       hdd;
  logic       mounted;
  logic       chg;
  logic [1:0] nf;
  logic [1:0] nh;
  logic [9:0] cyl;
  logic [5:0] sec;
  logic [5:0] sec_off;
  logic [11:0] base;
  logic [5:0]  spt;
  logic [17:0] lba_full;
  logic [bdsd_pkg::SizeW-1:0] secs;

  always_comb begin
    slot_vld = 1'b1;
    slot     = 2'd0;
    unique case (req_i.drive)
      bdsd_pkg::DrvA: slot = 2'd0;
      bdsd_pkg::DrvB: slot = 2'd1;
      bdsd_pkg::DrvC: slot = 2'd2;
      bdsd_pkg::DrvD: slot = 2'd3;
      default:        slot_vld = 1'b0;
    endcase
  end

  assign hdd     = slot[1];
  assign mounted = slot_vld & cfg_i.mounted_mask[slot];
  assign chg     = slot_vld & changed_i[slot];
  assign nf      = 2'd1 + {1'b0, cfg_i.mounted_mask[1]};
  assign nh      = {1'b0, cfg_i.mounted_mask[2]} + {1'b0, cfg_i.mounted_mask[3]};
  assign secs    = (slot == 2'd2) ? cfg_i.disk_c_sectors : cfg_i.disk_d_sectors;

  // chs to lba: floppy 2 heads x 18 sectors, hard disk 1 head x 63 sectors
  assign cyl      = {req_i.sec_cyl_high[7:6], req_i.cyl_low};
  assign sec      = req_i.sec_cyl_high[5:0];
  assign sec_off  = (sec == 6'd0) ? 6'd0 : sec - 6'd1;
  assign base     = hdd ? (12'(cyl) + 12'(req_i.head))
                        : ({1'b0, cyl, 1'b0} + 12'(req_i.head));
  assign spt      = hdd ? bdsd_pkg::HddSpt : bdsd_pkg::FloppySpt;
  assign lba_full = 18'(base * spt) + 18'(sec_off);

  always_comb begin
    changed_o           = changed_i;
    rsp_o.ret_ah        = req_i.func;
    rsp_o.ret_al        = req_i.count;
    rsp_o.ret_ch        = req_i.cyl_low;
    rsp_o.ret_cl        = req_i.sec_cyl_high;
    rsp_o.ret_dh        = req_i.head;
    rsp_o.ret_dl        = req_i.drive;
    rsp_o.ret_bl        = req_i.bl_in;
    rsp_o.carry         = 1'b0;
    rsp_o.transfer_kind = bdsd_pkg::XferNone;
    rsp_o.lba           = '0;
    rsp_o.phys_addr     = '0;
    rsp_o.byte_count    = '0;

    case (req_i.action)
      bdsd_pkg::ActNotice: begin
        if (slot_vld) changed_o[slot] = 1'b1;
      end
      bdsd_pkg::ActEquip: begin
        rsp_o.ret_al = bdsd_pkg::EquipBase | {1'b0, cfg_i.mounted_mask[1], 6'd0};
        rsp_o.ret_ah = bdsd_pkg::StOk;
      end
      bdsd_pkg::ActDisk: begin
        case (req_i.func) inside
          bdsd_pkg::FnReset, bdsd_pkg::FnSeek, bdsd_pkg::FnReady, bdsd_pkg::FnRecal,
          bdsd_pkg::FnVerify, bdsd_pkg::FnFormat, bdsd_pkg::FnSetType,
          bdsd_pkg::FnSetMedia: begin
            rsp_o.ret_ah = bdsd_pkg::StOk;
          end
          bdsd_pkg::FnStatus: begin
            rsp_o.ret_al = 8'd0;
          end
          bdsd_pkg::FnRead, bdsd_pkg::FnWrite: begin
            if (!mounted) begin
              rsp_o.ret_ah = bdsd_pkg::StTimeout;
              rsp_o.carry  = 1'b1;
            end else if (chg) begin
              changed_o[slot] = 1'b0;
              rsp_o.ret_ah    = bdsd_pkg::StChanged;
              rsp_o.carry     = 1'b1;
            end else begin
              rsp_o.lba           = lba_full[bdsd_pkg::LbaW-1:0];
              rsp_o.phys_addr     = {1'b0, req_i.buf_segment, 4'd0}
                                    + bdsd_pkg::PhysW'(req_i.buf_offset);
              rsp_o.byte_count    = {req_i.count, 9'd0};
              rsp_o.transfer_kind = (req_i.func == bdsd_pkg::FnRead) ? bdsd_pkg::XferRead
                                                                    : bdsd_pkg::XferWrite;
              if (req_i.transfer_ok) begin
                rsp_o.ret_ah = bdsd_pkg::StOk;
              end else begin
                rsp_o.ret_al = 8'd0;
                rsp_o.ret_ah = (req_i.func == bdsd_pkg::FnRead) ? bdsd_pkg::StReadErr
                                                                : bdsd_pkg::StWriteErr;
                rsp_o.carry  = 1'b1;
              end
            end
          end
          bdsd_pkg::FnParams: begin
            if (!slot_vld) begin
              rsp_o.ret_ah = bdsd_pkg::StBadFunc;
              rsp_o.carry  = 1'b1;
            end else begin
              rsp_o.ret_ah = bdsd_pkg::StOk;
              if (hdd) begin
                rsp_o.ret_ch = bdsd_pkg::HddMaxByte;
                rsp_o.ret_cl = bdsd_pkg::HddMaxByte;
                rsp_o.ret_dh = 8'd0;
                rsp_o.ret_dl = {6'd0, nh};
              end else begin
                rsp_o.ret_ch = bdsd_pkg::FloppyMaxCyl;
                rsp_o.ret_cl = 8'(bdsd_pkg::FloppySpt);
                rsp_o.ret_dh = 8'd1;
                rsp_o.ret_dl = {6'd0, nf};
                rsp_o.ret_bl = bdsd_pkg::FloppyBl;
              end
            end
          end
          bdsd_pkg::FnDiskType: begin
            if (!mounted) begin
              rsp_o.ret_ah = bdsd_pkg::StOk;
            end else if (hdd) begin
              rsp_o.ret_ah = bdsd_pkg::StHardDisk;
              rsp_o.ret_ch = 8'd0;
              rsp_o.ret_cl = {1'b0, secs[22:16]};
              rsp_o.ret_dh = secs[15:8];
              rsp_o.ret_dl = secs[7:0];
            end else begin
              rsp_o.ret_ah = bdsd_pkg::StFloppy;
            end
          end
          bdsd_pkg::FnChange: begin
            if (chg) begin
              changed_o[slot] = 1'b0;
              rsp_o.ret_ah    = bdsd_pkg::StChanged;
              rsp_o.carry     = 1'b1;
            end else begin
              rsp_o.ret_ah = bdsd_pkg::StOk;
            end
          end
          default: begin
            rsp_o.ret_ah = bdsd_pkg::StBadFunc;
            rsp_o.carry  = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/bios_disk_service_dispatch_core.sv
// disk-service dispatcher for pc bios style int 13h requests
// slave stream carries one request per transaction: tuser is the action
// (disk service, media-change notice, equipment query), tdata the register
// image of the call and the transfer_ok flag of the storage backend.
// master stream returns one result per request: the updated registers and
// carry in tdata, the transfer kind in tuser, plus lba, physical address
// and byte count for reads and writes.
// the config channel writes mounted_mask and the two hard disk sizes; it is
// always ready and should only be used while no request is in flight.
// the result passes an input register, the decode and chs/address math,
// then the result register. throughput is one request per cycle while
// the receiver keeps up; the media-change flags are read and updated in
// the same cycle, so back-to-back requests see each other's effects in
// order. when the receiver stalls, the result register holds and the
// input register still takes one more request before tready drops.
// reset clears the media-change flags, the config registers and both valids.
module bios_disk_service_dispatch_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [22:0]  cfg_data_i,
  // request stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // func, count, cyl_low, sec_cyl_high, head, drive, bl_in, buf_offset,
  // buf_segment, transfer_ok, zero pad
  input  logic [95:0]  s_axis_tdata_i,
  // action
  input  logic [1:0]   s_axis_tuser_i,
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // ret_ah, ret_al, ret_ch, ret_cl, ret_dh, ret_dl, ret_bl, carry, lba,
  // phys_addr, byte_count
  output logic [111:0] m_axis_tdata_o,
  // transfer_kind
  output logic [1:0]   m_axis_tuser_o
);

  bdsd_pkg::cfg_t cfg_q;
  logic [3:0]     changed_q, changed_d;
  logic           in_vld_q;
  bdsd_pkg::req_t req_q, req_d;
  logic           out_vld_q;
  bdsd_pkg::rsp_t rsp_q, rsp_d;
  logic           advance;
  logic           in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bdsd_pkg::CfgMounted: cfg_q.mounted_mask   <= cfg_data_i[3:0];
        bdsd_pkg::CfgDiskC:   cfg_q.disk_c_sectors <= cfg_data_i;
        bdsd_pkg::CfgDiskD:   cfg_q.disk_d_sectors <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    req_d.action       = s_axis_tuser_i;
    req_d.func         = s_axis_tdata_i[7:0];
    req_d.count        = s_axis_tdata_i[15:8];
    req_d.cyl_low      = s_axis_tdata_i[23:16];
    req_d.sec_cyl_high = s_axis_tdata_i[31:24];
    req_d.head         = s_axis_tdata_i[39:32];
    req_d.drive        = s_axis_tdata_i[47:40];
    req_d.bl_in        = s_axis_tdata_i[55:48];
    req_d.buf_offset   = s_axis_tdata_i[71:56];
    req_d.buf_segment  = s_axis_tdata_i[87:72];
    req_d.transfer_ok  = s_axis_tdata_i[88];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) req_q <= req_d;
  end

  bdsd_exec u_exec (
    .req_i     (req_q),
    .cfg_i     (cfg_q),
    .changed_i (changed_q),
    .changed_o (changed_d),
    .rsp_o     (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) changed_q <= changed_d;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) rsp_q <= rsp_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = rsp_q.transfer_kind;
  assign m_axis_tdata_o  = {rsp_q.byte_count, rsp_q.phys_addr, rsp_q.lba, rsp_q.carry,
                            rsp_q.ret_bl, rsp_q.ret_dl, rsp_q.ret_dh, rsp_q.ret_cl,
                            rsp_q.ret_ch, rsp_q.ret_al, rsp_q.ret_ah};

endmodule

// File: tb/tb.sv
module tb;

  // action code with no meaning of its own, answered like an empty notice
  localparam logic [1:0] ActSpare = 2'd3;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned NumPhases = 6;

  class disk_call_scoreboard;
    logic [3:0]     mounted;
    logic [22:0]    c_secs;
    logic [22:0]    d_secs;
    logic [3:0]     changed;
    bdsd_pkg::rsp_t pending_q[$];
    int             errors;
    int             checked;

    function new();
      mounted = '0;
      c_secs = '0;
      d_secs = '0;
      changed = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [22:0] val);
      case (idx)
        bdsd_pkg::CfgMounted: mounted = val[3:0];
        bdsd_pkg::CfgDiskC:   c_secs = val;
        bdsd_pkg::CfgDiskD:   d_secs = val;
        default: ;
      endcase
    endfunction

    function int slot_of(logic [7:0] drv);
      case (drv)
        bdsd_pkg::DrvA: return 0;
        bdsd_pkg::DrvB: return 1;
        bdsd_pkg::DrvC: return 2;
        bdsd_pkg::DrvD: return 3;
        default:        return -1;
      endcase
    endfunction

    function bit is_mounted(int slot);
      return slot >= 0 && mounted[slot];
    endfunction

    // a pending media change is cleared by the call that reports it
    function bit consume_change(int slot);
      if (slot < 0 || !changed[slot]) return 1'b0;
      changed[slot] = 1'b0;
      return 1'b1;
    endfunction

    function void note_request(bdsd_pkg::req_t r);
      bdsd_pkg::rsp_t e;
      int             slot;
      int             cyl;
      int             sec;
      int             heads;
      int             spt;
      int             lba_full;
      logic [7:0]     nf;
      logic [7:0]     nh;
      logic [22:0]    secs;
      e.ret_ah = r.func;
      e.ret_al = r.count;
      e.ret_ch = r.cyl_low;
      e.ret_cl = r.sec_cyl_high;
      e.ret_dh = r.head;
      e.ret_dl = r.drive;
      e.ret_bl = r.bl_in;
      e.carry = 1'b0;
      e.transfer_kind = bdsd_pkg::XferNone;
      e.lba = '0;
      e.phys_addr = '0;
      e.byte_count = '0;
      slot = slot_of(r.drive);
      nf = 8'd1 + 8'(mounted[1]);
      nh = 8'(mounted[2]) + 8'(mounted[3]);
      case (r.action)
        bdsd_pkg::ActNotice: if (slot >= 0) changed[slot] = 1'b1;
        bdsd_pkg::ActEquip: begin
          e.ret_al = bdsd_pkg::EquipBase | ((nf - 8'd1) << 6);
          e.ret_ah = bdsd_pkg::StOk;
        end
        bdsd_pkg::ActDisk: begin
          case (r.func)
            bdsd_pkg::FnReset, bdsd_pkg::FnSeek, bdsd_pkg::FnReady, bdsd_pkg::FnRecal,
            bdsd_pkg::FnVerify, bdsd_pkg::FnFormat, bdsd_pkg::FnSetType,
            bdsd_pkg::FnSetMedia:
              e.ret_ah = bdsd_pkg::StOk;
            bdsd_pkg::FnStatus: e.ret_al = 8'd0;
            bdsd_pkg::FnRead, bdsd_pkg::FnWrite: begin
              if (!is_mounted(slot)) begin
                e.ret_ah = bdsd_pkg::StTimeout;
                e.carry = 1'b1;
              end else if (consume_change(slot)) begin
                e.ret_ah = bdsd_pkg::StChanged;
                e.carry = 1'b1;
              end else begin
                cyl = {r.sec_cyl_high[7:6], r.cyl_low};
                sec = r.sec_cyl_high[5:0];
                heads = (slot >= 2) ? 1 : 2;
                spt = (slot >= 2) ? int'(bdsd_pkg::HddSpt) : int'(bdsd_pkg::FloppySpt);
                lba_full = (cyl * heads + r.head) * spt + ((sec != 0) ? sec - 1 : 0);
                e.lba = 17'(lba_full);
                e.phys_addr = 21'(int'(r.buf_segment) * 16 + int'(r.buf_offset));
                e.byte_count = 17'(int'(r.count) * 512);
                e.transfer_kind = (r.func == bdsd_pkg::FnRead) ? bdsd_pkg::XferRead
                                                               : bdsd_pkg::XferWrite;
                if (r.transfer_ok) begin
                  e.ret_ah = bdsd_pkg::StOk;
                end else begin
                  e.ret_al = 8'd0;
                  e.ret_ah = (r.func == bdsd_pkg::FnRead) ? bdsd_pkg::StReadErr
                                                          : bdsd_pkg::StWriteErr;
                  e.carry = 1'b1;
                end
              end
            end
            bdsd_pkg::FnParams: begin
              if (slot < 0) begin
                e.ret_ah = bdsd_pkg::StBadFunc;
                e.carry = 1'b1;
              end else begin
                if (slot >= 2) begin
                  e.ret_ch = bdsd_pkg::HddMaxByte;
                  e.ret_cl = bdsd_pkg::HddMaxByte;
                  e.ret_dh = 8'd0;
                  e.ret_dl = nh;
                end else begin
                  e.ret_ch = bdsd_pkg::FloppyMaxCyl;
                  e.ret_cl = 8'(bdsd_pkg::FloppySpt);
                  e.ret_dh = 8'd1;
                  e.ret_dl = nf;
                  e.ret_bl = bdsd_pkg::FloppyBl;
                end
                e.ret_ah = bdsd_pkg::StOk;
              end
            end
            bdsd_pkg::FnDiskType: begin
              if (!is_mounted(slot)) begin
                e.ret_ah = bdsd_pkg::StOk;
              end else if (slot >= 2) begin
                secs = (slot == 2) ? c_secs : d_secs;
                e.ret_ah = bdsd_pkg::StHardDisk;
                e.ret_ch = 8'd0;
                e.ret_cl = {1'b0, secs[22:16]};
                e.ret_dh = secs[15:8];
                e.ret_dl = secs[7:0];
              end else begin
                e.ret_ah = bdsd_pkg::StFloppy;
              end
            end
            bdsd_pkg::FnChange: begin
              if (consume_change(slot)) begin
                e.ret_ah = bdsd_pkg::StChanged;
                e.carry = 1'b1;
              end else begin
                e.ret_ah = bdsd_pkg::StOk;
              end
            end
            default: begin
              e.ret_ah = bdsd_pkg::StBadFunc;
              e.carry = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
      pending_q.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(bdsd_pkg::rsp_t got);
      bdsd_pkg::rsp_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, got 0x%0h", $time, got);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      cmp("ret_ah", e.ret_ah, got.ret_ah);
      cmp("ret_al", e.ret_al, got.ret_al);
      cmp("ret_ch", e.ret_ch, got.ret_ch);
      cmp("ret_cl", e.ret_cl, got.ret_cl);
      cmp("ret_dh", e.ret_dh, got.ret_dh);
      cmp("ret_dl", e.ret_dl, got.ret_dl);
      cmp("ret_bl", e.ret_bl, got.ret_bl);
      cmp("carry", e.carry, got.carry);
      cmp("transfer_kind", e.transfer_kind, got.transfer_kind);
      cmp("lba", e.lba, got.lba);
      cmp("phys_addr", e.phys_addr, got.phys_addr);
      cmp("byte_count", e.byte_count, got.byte_count);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [22:0]  cfg_data_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  disk_call_scoreboard sb = new();
  bit quiet_mode = 1'b0;
  int ready_hold = 0;
  int n_sent = 0;
  int n_phases = 0;

  bios_disk_service_dispatch_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly back to back, sometimes a short gap, rarely a long pause; none in quiet mode
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet_mode || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (quiet_mode || $urandom_range(0, 99) < 65) begin
      m_axis_tready_i <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end else begin
      m_axis_tready_i <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  // transaction monitors on both streams
  always @(posedge clk_i) begin
    bdsd_pkg::req_t rq;
    bdsd_pkg::rsp_t rs;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      rq.action = s_axis_tuser_i;
      rq.func = s_axis_tdata_i[7:0];
      rq.count = s_axis_tdata_i[15:8];
      rq.cyl_low = s_axis_tdata_i[23:16];
      rq.sec_cyl_high = s_axis_tdata_i[31:24];
      rq.head = s_axis_tdata_i[39:32];
      rq.drive = s_axis_tdata_i[47:40];
      rq.bl_in = s_axis_tdata_i[55:48];
      rq.buf_offset = s_axis_tdata_i[71:56];
      rq.buf_segment = s_axis_tdata_i[87:72];
      rq.transfer_ok = s_axis_tdata_i[88];
      sb.note_request(rq);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      rs.ret_ah = m_axis_tdata_o[7:0];
      rs.ret_al = m_axis_tdata_o[15:8];
      rs.ret_ch = m_axis_tdata_o[23:16];
      rs.ret_cl = m_axis_tdata_o[31:24];
      rs.ret_dh = m_axis_tdata_o[39:32];
      rs.ret_dl = m_axis_tdata_o[47:40];
      rs.ret_bl = m_axis_tdata_o[55:48];
      rs.carry = m_axis_tdata_o[56];
      rs.lba = m_axis_tdata_o[73:57];
      rs.phys_addr = m_axis_tdata_o[94:74];
      rs.byte_count = m_axis_tdata_o[111:95];
      rs.transfer_kind = m_axis_tuser_o;
      sb.check_result(rs);
    end
  end

  task automatic send(bdsd_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= r.action;
    s_axis_tdata_i <= {7'd0, r.transfer_ok, r.buf_segment, r.buf_offset, r.bl_in, r.drive,
                       r.head, r.sec_cyl_high, r.cyl_low, r.count, r.func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
  endtask

  task automatic configure(logic [3:0] mask, logic [22:0] c_size, logic [22:0] d_size);
    logic [22:0] vals[3];
    vals[0] = {19'd0, mask};
    vals[1] = c_size;
    vals[2] = d_size;
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
    n_phases++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic bdsd_pkg::req_t rand_req();
    bdsd_pkg::req_t r;
    r.action = 2'($urandom_range(0, 3));
    r.func = 8'($urandom);
    r.count = 8'($urandom);
    r.cyl_low = 8'($urandom);
    r.sec_cyl_high = 8'($urandom);
    r.head = 8'($urandom);
    r.drive = 8'($urandom);
    r.bl_in = 8'($urandom);
    r.buf_offset = 16'($urandom);
    r.buf_segment = 16'($urandom);
    r.transfer_ok = 1'($urandom);
    return r;
  endfunction

  function automatic bdsd_pkg::req_t svc(logic [1:0] act, logic [7:0] fn, logic [7:0] drv,
                                         logic ok);
    bdsd_pkg::req_t r;
    r = rand_req();
    r.action = act;
    r.func = fn;
    r.drive = drv;
    r.transfer_ok = ok;
    return r;
  endfunction

  task automatic run_random(int n);
    logic [7:0] known_fn[14];
    logic [7:0] drives[4];
    bdsd_pkg::req_t r;
    int p;
    known_fn = '{bdsd_pkg::FnReset, bdsd_pkg::FnStatus, bdsd_pkg::FnRead, bdsd_pkg::FnWrite,
                 bdsd_pkg::FnVerify, bdsd_pkg::FnFormat, bdsd_pkg::FnParams, bdsd_pkg::FnSeek,
                 bdsd_pkg::FnReady, bdsd_pkg::FnRecal, bdsd_pkg::FnDiskType,
                 bdsd_pkg::FnChange, bdsd_pkg::FnSetType, bdsd_pkg::FnSetMedia};
    drives = '{bdsd_pkg::DrvA, bdsd_pkg::DrvB, bdsd_pkg::DrvC, bdsd_pkg::DrvD};
    for (int i = 0; i < n; i++) begin
      r = rand_req();
      p = $urandom_range(0, 99);
      r.action = (p < 80) ? bdsd_pkg::ActDisk : (p < 92) ? bdsd_pkg::ActNotice
               : (p < 97) ? bdsd_pkg::ActEquip : ActSpare;
      p = $urandom_range(0, 99);
      if (p < 45) begin
        r.func = ($urandom_range(0, 1) != 0) ? bdsd_pkg::FnRead : bdsd_pkg::FnWrite;
      end else if (p < 80) begin
        r.func = known_fn[$urandom_range(0, 13)];
      end
      if ($urandom_range(0, 99) < 85) r.drive = drives[$urandom_range(0, 3)];
      r.transfer_ok = ($urandom_range(0, 99) < 85);
      send(r);
    end
  endtask

  initial begin
    bdsd_pkg::req_t r;
    logic [3:0] mask;
    logic [22:0] c_size;
    logic [22:0] d_size;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= bdsd_pkg::CfgMounted;
    cfg_data_i <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= bdsd_pkg::ActDisk;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: floppy B left unmounted
    configure(4'b1101, 23'h7FFFFF, 23'h123456);
    send(svc(bdsd_pkg::ActEquip, bdsd_pkg::FnReset, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnReset, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnStatus, bdsd_pkg::DrvC, 1'b1));
    r = svc(bdsd_pkg::ActDisk, bdsd_pkg::FnRead, bdsd_pkg::DrvA, 1'b1);
    r.count = 8'hFF;
    r.cyl_low = 8'hFF;
    r.sec_cyl_high = 8'hFF;
    r.head = 8'hFF;
    r.buf_offset = 16'hFFFF;
    r.buf_segment = 16'hFFFF;
    send(r);
    // sector field of zero counts like sector one
    r = svc(bdsd_pkg::ActDisk, bdsd_pkg::FnWrite, bdsd_pkg::DrvC, 1'b1);
    r.count = 8'h00;
    r.cyl_low = 8'h00;
    r.sec_cyl_high = 8'h00;
    r.head = 8'h00;
    r.buf_offset = 16'h0000;
    r.buf_segment = 16'h0000;
    send(r);
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnRead, bdsd_pkg::DrvD, 1'b0));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnWrite, bdsd_pkg::DrvA, 1'b0));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnWrite, bdsd_pkg::DrvB, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnRead, 8'h7F, 1'b1));
    send(svc(bdsd_pkg::ActNotice, bdsd_pkg::FnRead, bdsd_pkg::DrvC, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnRead, bdsd_pkg::DrvC, 1'b1));
    r = svc(bdsd_pkg::ActDisk, bdsd_pkg::FnRead, bdsd_pkg::DrvC, 1'b1);
    r.cyl_low = 8'hFF;
    r.sec_cyl_high = 8'hFF;
    r.head = 8'hFF;
    send(r);
    send(svc(bdsd_pkg::ActNotice, bdsd_pkg::FnRead, 8'hFF, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnParams, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnParams, bdsd_pkg::DrvC, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnParams, 8'h02, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnDiskType, bdsd_pkg::DrvB, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnDiskType, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnDiskType, bdsd_pkg::DrvD, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnDiskType, 8'h42, 1'b1));
    send(svc(bdsd_pkg::ActNotice, bdsd_pkg::FnChange, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnChange, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnChange, bdsd_pkg::DrvA, 1'b1));
    send(svc(bdsd_pkg::ActDisk, bdsd_pkg::FnSetMedia, bdsd_pkg::DrvB, 1'b1));
    send(svc(bdsd_pkg::ActDisk, 8'hFF, bdsd_pkg::DrvA, 1'b1));
    send(svc(ActSpare, bdsd_pkg::FnRead, bdsd_pkg::DrvC, 1'b1));
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      mask = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : 4'($urandom);
      c_size = (p == 1) ? 23'd0 : (p == 2) ? 23'h7FFFFF : 23'($urandom);
      d_size = (p == 1) ? 23'h7FFFFF : (p == 2) ? 23'd0 : 23'($urandom);
      configure(mask, c_size, d_size);
      quiet_mode = (p == 3);
      run_random(ItemsPerPhase);
      drain();
    end
    quiet_mode = 1'b0;

    repeat (10) @(posedge clk_i);
    $display("sent %0d requests over %0d register settings, %0d results compared",
             n_sent, n_phases, sb.checked);
    $display("left pending: %0d, mismatches: %0d", sb.pending_q.size(), sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results still pending", sb.pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/bdsd_pkg.sv
sv/bdsd_exec.sv
sv/bios_disk_service_dispatch_core.sv
tb/tb.sv
